@@ design/ahhs_pkg.sv @@
// shared types and constants for the adaptive hough helix search block
// no dependencies; used by every module of the block by scoped names
package ahhs_pkg;

    localparam int MAX_POINTS_DEF    = 1024;
    localparam int LIST_DEPTH_DEF    = 4096;
    localparam int STACK_DEPTH_DEF   = 64;
    localparam int MAX_SOLUTIONS_DEF = 32;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_MIN  = 4'd0,
        CFG_Q_MAX  = 4'd1,
        CFG_P_MIN  = 4'd2,
        CFG_P_MAX  = 4'd3,
        CFG_THRESH = 4'd4,
        CFG_Q_LEV  = 4'd5,
        CFG_P_LEV  = 4'd6,
        CFG_GAIN   = 4'd7
    } t_cfg_idx;

    localparam logic signed [15:0] Q_MIN_RST  = -16'sd32768;
    localparam logic signed [15:0] Q_MAX_RST  = 16'sd32767;
    localparam logic signed [15:0] P_MIN_RST  = -16'sd32768;
    localparam logic signed [15:0] P_MAX_RST  = 16'sd32767;
    localparam logic [7:0]         THRESH_RST = 8'd6;
    localparam logic [3:0]         Q_LEV_RST  = 4'd8;
    localparam logic [3:0]         P_LEV_RST  = 4'd8;
    localparam logic [15:0]        GAIN_RST   = 16'd4096;

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam int DIV_BITS   = 44;
    localparam int BEND_SHIFT = 28;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam logic [7:0]  HIT_SAT      = 8'd255;

    typedef struct packed {
        logic               command;
        logic [15:0]        point_radius;
        logic signed [15:0] point_angle;
    } t_in;

    typedef struct packed {
        logic               solution_valid;
        logic [7:0]         hit_count;
        logic signed [31:0] track_radius;
        logic signed [15:0] track_angle;
        logic               overflow;
        logic               is_last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic pop;
        logic latch;
        logic child;
        logic rd;
        logic pt;
        logic m1;
        logic m2;
        logic cmp;
        logic push;
        logic next;
        logic leaf;
        logic div_start;
        logic emit;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic hits_low;
        logic leaf;
        logic last_child;
        logic stack_full;
        logic scan_empty;
        logic scan_done;
        logic sol_full;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ design/ahhs_div.sv @@
// restoring divider for the track radius, one quotient bit per cycle
// uses ahhs_pkg for the quotient length
module ahhs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_den,
    output logic [ahhs_pkg::DIV_BITS-1:0] o_quo,
    output logic                          o_done
);
    localparam int QW = ahhs_pkg::DIV_BITS;
    localparam int CW = $clog2(QW);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   r_rem;
    logic [QW-1:0] r_quo;
    logic          numbit;
    logic [32:0]   trial;

    // the dividend is a single one at its top bit
    assign numbit = (r_cnt == '0);
    assign trial  = {r_rem[31:0], numbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_den}) begin
                r_rem <= trial - {1'b0, i_den};
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
            if (r_cnt == CW'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

@@ design/ahhs_ctrl.sv @@
// search sequencer: walks loads, cell pops, child scans, leaves and the end marker
// uses ahhs_pkg command and status structs; drives ahhs_dp
module ahhs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_command,
    output logic           o_in_stall,
    input  ahhs_pkg::t_sts i_sts,
    output ahhs_pkg::t_cmd o_cmd
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_POP, ST_LATCH, ST_EVAL, ST_CHILD, ST_RD, ST_PT, ST_M1, ST_M2,
        ST_CMP, ST_PUSH, ST_NEXT, ST_LEAF, ST_DIVS, ST_DIVW, ST_EMIT, ST_END
    } t_state;

    t_state         r_state;
    t_state         n_state;
    ahhs_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == ahhs_pkg::CMD_START) begin
                        cmd.start = 1'b1;
                        n_state   = ST_POP;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_POP: begin
                if (i_sts.stack_empty) begin
                    n_state = ST_END;
                end else begin
                    cmd.pop = 1'b1;
                    n_state = ST_LATCH;
                end
            end
            ST_LATCH: begin
                cmd.latch = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.hits_low) begin
                    n_state = ST_POP;
                end else if (i_sts.leaf) begin
                    n_state = ST_LEAF;
                end else begin
                    n_state = ST_CHILD;
                end
            end
            ST_CHILD: begin
                cmd.child = 1'b1;
                if (i_sts.stack_full) begin
                    n_state = ST_NEXT;
                end else if (i_sts.scan_empty) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd  = 1'b1;
                n_state = ST_PT;
            end
            ST_PT: begin
                cmd.pt  = 1'b1;
                n_state = ST_M1;
            end
            ST_M1: begin
                cmd.m1  = 1'b1;
                n_state = ST_M2;
            end
            ST_M2: begin
                cmd.m2  = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
                n_state = i_sts.scan_done ? ST_PUSH : ST_RD;
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                n_state  = ST_NEXT;
            end
            ST_NEXT: begin
                if (i_sts.last_child) begin
                    n_state = ST_POP;
                end else begin
                    cmd.next = 1'b1;
                    n_state  = ST_CHILD;
                end
            end
            ST_LEAF: begin
                cmd.leaf = 1'b1;
                n_state  = i_sts.sol_full ? ST_POP : ST_DIVS;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                n_state       = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_POP;
                end
            end
            ST_END: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != ST_IDLE);
endmodule

@@ design/ahhs_dp.sv @@
// datapath: config registers, point stores, point list, cell stack, hit test,
// radius divider and output register; uses ahhs_pkg and ahhs_div
module ahhs_dp #(
    parameter int MAX_POINTS    = ahhs_pkg::MAX_POINTS_DEF,
    parameter int LIST_DEPTH    = ahhs_pkg::LIST_DEPTH_DEF,
    parameter int STACK_DEPTH   = ahhs_pkg::STACK_DEPTH_DEF,
    parameter int MAX_SOLUTIONS = ahhs_pkg::MAX_SOLUTIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ahhs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ahhs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ahhs_pkg::t_in                     i_in_data,
    input  ahhs_pkg::t_cmd                    i_cmd,
    output ahhs_pkg::t_sts                    o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output ahhs_pkg::t_out                    o_out_data
);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int LW  = $clog2(LIST_DEPTH);
    localparam int LCW = $clog2(LIST_DEPTH + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int NW  = $clog2(MAX_SOLUTIONS + 1);
    localparam int BS  = ahhs_pkg::BEND_SHIFT;
    localparam int QW  = ahhs_pkg::DIV_BITS;

    localparam logic [PCW-1:0]     PCOUNT_MAX = PCW'(MAX_POINTS);
    localparam logic [LCW-1:0]     LIST_MAX   = LCW'(LIST_DEPTH);
    localparam logic [SCW-1:0]     STACK_MAX  = SCW'(STACK_DEPTH);
    localparam logic [NW-1:0]      SOL_MAX    = NW'(MAX_SOLUTIONS);
    localparam logic signed [17:0] HALF18     = 18'sd32768;
    localparam logic [QW-1:0]      POS_LIM    = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0]      NEG_LIM    = QW'(32'h8000_0000);

    typedef struct packed {
        logic signed [15:0] qlo;
        logic signed [15:0] qhi;
        logic signed [17:0] plo;
        logic signed [17:0] phi;
        logic [LCW-1:0]     lbeg;
        logic [LCW-1:0]     lend;
        logic [3:0]         qlev;
        logic [3:0]         plev;
    } t_cell;

    // configuration
    logic signed [15:0] r_qmin, r_qmax, r_pmin, r_pmax;
    logic [7:0]         r_thresh;
    logic [3:0]         r_qlev_max, r_plev_max;
    logic [15:0]        r_gain;

    // memories
    logic [15:0] m_rad   [MAX_POINTS];
    logic [15:0] m_ang   [MAX_POINTS];
    logic [PW-1:0] m_list [LIST_DEPTH];
    t_cell       m_stack [STACK_DEPTH];

    // control state
    logic [PCW-1:0] r_pcount;
    logic           r_load_ovf, r_run_ovf, r_rot;
    logic [LCW-1:0] r_root_n;
    logic [SCW-1:0] r_scount;
    logic [NW-1:0]  r_nsol;
    logic [1:0]     r_k;
    logic           r_oval;

    // payload
    t_cell              r_par, r_child, r_stack_q;
    logic [LCW-1:0]     r_cursor, r_pos;
    logic               r_ident;
    logic [PW-1:0]      r_list_q, r_idx;
    logic [15:0]        r_rad_q, r_ang_q;
    logic [31:0]        r_rb;
    logic signed [48:0] r_blo, r_bhi;
    logic [31:0]        r_den;
    logic               r_qneg;
    logic [7:0]         r_sol_hits;
    logic [15:0]        r_sol_ang;
    ahhs_pkg::t_out     r_out;

    // combinational helpers
    logic               rot;
    logic [LCW-1:0]     root_n;
    t_cell              root, child;
    logic [LCW-1:0]     hits;
    logic               sq, sp;
    logic signed [16:0] qsum;
    logic signed [18:0] psum;
    logic signed [15:0] qm;
    logic signed [17:0] pm;
    logic               qhalf;
    logic [PW-1:0]      idx;
    logic signed [15:0] ang;
    logic signed [22:0] left_v, right_v;
    logic               hit, list_full;
    logic [15:0]        qabs;
    logic [QW-1:0]      quo;
    logic               div_done;
    logic [31:0]        mag, radius;

    // root cell; a wrapping region is turned by a half turn
    always_comb begin
        rot       = r_pmin > r_pmax;
        root_n    = (32'(r_pcount) > 32'(LIST_DEPTH)) ? LIST_MAX : LCW'(r_pcount);
        root.qlo  = r_qmin;
        root.qhi  = r_qmax;
        root.plo  = {{2{r_pmin[15]}}, r_pmin} - (rot ? HALF18 : 18'sd0);
        root.phi  = {{2{r_pmax[15]}}, r_pmax} + (rot ? HALF18 : 18'sd0);
        root.lbeg = '0;
        root.lend = root_n;
        root.qlev = '0;
        root.plev = '0;
    end

    // split of the current parent cell
    always_comb begin
        hits  = r_par.lend - r_par.lbeg;
        sq    = r_par.qlev < r_qlev_max;
        sp    = r_par.plev < r_plev_max;
        qsum  = {r_par.qlo[15], r_par.qlo} + {r_par.qhi[15], r_par.qhi};
        psum  = {r_par.plo[17], r_par.plo} + {r_par.phi[17], r_par.phi};
        qm    = qsum[16:1];
        pm    = psum[18:1];
        qhalf = (sq && sp) ? r_k[1] : r_k[0];
        child.qlo  = (sq && qhalf)  ? qm : r_par.qlo;
        child.qhi  = (sq && !qhalf) ? qm : r_par.qhi;
        child.plo  = (sp && r_k[0])  ? pm : r_par.plo;
        child.phi  = (sp && !r_k[0]) ? pm : r_par.phi;
        child.lbeg = r_cursor;
        child.lend = r_cursor;
        child.qlev = r_par.qlev + {3'b0, sq};
        child.plev = r_par.plev + {3'b0, sp};
        qabs  = qm[15] ? 16'(-qm) : 16'(qm);
    end

    // hit test: bend is floor(r*b*q / 2^28)
    always_comb begin
        idx     = r_ident ? PW'(r_pos) : r_list_q;
        ang     = $signed(r_ang_q ^ (r_rot ? ahhs_pkg::HALF_TURN : 16'h0000));
        left_v  = {{7{ang[15]}}, ang} - {{2{r_blo[48]}}, r_blo[48:BS]};
        right_v = {{7{ang[15]}}, ang} - {{2{r_bhi[48]}}, r_bhi[48:BS]};
        hit     = (left_v >= $signed({{5{r_child.plo[17]}}, r_child.plo}))
               && (right_v <= $signed({{5{r_child.phi[17]}}, r_child.phi}));
        list_full = r_child.lend >= LIST_MAX;
    end

    // radius saturation
    always_comb begin
        mag = 32'h0;
        if (r_den == 32'h0) begin
            radius = 32'h7FFF_FFFF;
        end else if (r_qneg) begin
            mag    = (quo > NEG_LIM) ? 32'h8000_0000 : quo[31:0];
            radius = 32'h0 - mag;
        end else begin
            radius = (quo > POS_LIM) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    always_comb begin
        o_sts.stack_empty = (r_scount == '0);
        o_sts.hits_low    = 32'(hits) < 32'(r_thresh);
        o_sts.leaf        = !sq && !sp;
        o_sts.last_child  = (sq && sp) ? (r_k == 2'd3) : (r_k == 2'd1);
        o_sts.stack_full  = r_scount >= STACK_MAX;
        o_sts.scan_empty  = r_par.lbeg == r_par.lend;
        o_sts.scan_done   = (hit && list_full) || ((r_pos + 1'b1) == r_par.lend);
        o_sts.sol_full    = r_nsol >= SOL_MAX;
        o_sts.div_done    = div_done;
        o_sts.out_free    = !r_oval || !i_out_stall;
    end

    ahhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_den   (r_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // point stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_pcount < PCOUNT_MAX)) begin
            m_rad[PW'(r_pcount)] <= i_in_data.point_radius;
            m_ang[PW'(r_pcount)] <= i_in_data.point_angle;
        end
        if (i_cmd.pt) begin
            r_rad_q <= m_rad[idx];
            r_ang_q <= m_ang[idx];
        end
    end

    // point list
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && hit && !list_full) begin
            m_list[r_child.lend[LW-1:0]] <= r_idx;
        end
        if (i_cmd.rd) begin
            r_list_q <= m_list[r_pos[LW-1:0]];
        end
    end

    // cell stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            m_stack[0] <= root;
        end else if (i_cmd.push) begin
            m_stack[SW'(r_scount)] <= r_child;
        end
        if (i_cmd.pop) begin
            r_stack_q <= m_stack[SW'(r_scount - 1'b1)];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_par    <= r_stack_q;
            r_cursor <= r_stack_q.lend;
        end
        if (i_cmd.child) begin
            r_child <= child;
            r_pos   <= r_par.lbeg;
        end
        if (i_cmd.rd) begin
            r_ident <= r_pos < r_root_n;
        end
        if (i_cmd.pt) begin
            r_idx <= idx;
        end
        if (i_cmd.m1) begin
            r_rb <= r_rad_q * r_gain;
        end
        if (i_cmd.m2) begin
            r_blo <= $signed({1'b0, r_rb}) * r_child.qlo;
            r_bhi <= $signed({1'b0, r_rb}) * r_child.qhi;
        end
        if (i_cmd.cmp) begin
            r_pos <= r_pos + 1'b1;
            if (hit && !list_full) begin
                r_child.lend <= r_child.lend + 1'b1;
            end
        end
        if (i_cmd.push) begin
            r_cursor <= r_child.lend;
        end
        if (i_cmd.leaf) begin
            r_den      <= qabs * r_gain;
            r_qneg     <= qm[15];
            r_sol_hits <= (32'(hits) > 32'(ahhs_pkg::HIT_SAT)) ? ahhs_pkg::HIT_SAT : hits[7:0];
            r_sol_ang  <= pm[15:0] + ahhs_pkg::QUARTER_TURN
                        + (r_rot ? ahhs_pkg::HALF_TURN : 16'h0000);
        end
        if (i_cmd.emit) begin
            r_out.solution_valid <= 1'b1;
            r_out.hit_count      <= r_sol_hits;
            r_out.track_radius   <= $signed(radius);
            r_out.track_angle    <= $signed(r_sol_ang);
            r_out.overflow       <= 1'b0;
            r_out.is_last        <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out.solution_valid <= 1'b0;
            r_out.hit_count      <= '0;
            r_out.track_radius   <= '0;
            r_out.track_angle    <= '0;
            r_out.overflow       <= r_run_ovf;
            r_out.is_last        <= 1'b1;
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmin     <= ahhs_pkg::Q_MIN_RST;
            r_qmax     <= ahhs_pkg::Q_MAX_RST;
            r_pmin     <= ahhs_pkg::P_MIN_RST;
            r_pmax     <= ahhs_pkg::P_MAX_RST;
            r_thresh   <= ahhs_pkg::THRESH_RST;
            r_qlev_max <= ahhs_pkg::Q_LEV_RST;
            r_plev_max <= ahhs_pkg::P_LEV_RST;
            r_gain     <= ahhs_pkg::GAIN_RST;
            r_pcount   <= '0;
            r_load_ovf <= 1'b0;
            r_run_ovf  <= 1'b0;
            r_rot      <= 1'b0;
            r_root_n   <= '0;
            r_scount   <= '0;
            r_nsol     <= '0;
            r_k        <= '0;
            r_oval     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (ahhs_pkg::t_cfg_idx'(i_cfg_index))
                    ahhs_pkg::CFG_Q_MIN:  r_qmin     <= $signed(i_cfg_data);
                    ahhs_pkg::CFG_Q_MAX:  r_qmax     <= $signed(i_cfg_data);
                    ahhs_pkg::CFG_P_MIN:  r_pmin     <= $signed(i_cfg_data);
                    ahhs_pkg::CFG_P_MAX:  r_pmax     <= $signed(i_cfg_data);
                    ahhs_pkg::CFG_THRESH: r_thresh   <= i_cfg_data[7:0];
                    ahhs_pkg::CFG_Q_LEV:  r_qlev_max <= i_cfg_data[3:0];
                    ahhs_pkg::CFG_P_LEV:  r_plev_max <= i_cfg_data[3:0];
                    ahhs_pkg::CFG_GAIN:   r_gain     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (r_pcount < PCOUNT_MAX) begin
                    r_pcount <= r_pcount + 1'b1;
                end else begin
                    r_load_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_run_ovf <= r_load_ovf || (32'(r_pcount) > 32'(LIST_DEPTH));
                r_rot     <= rot;
                r_root_n  <= root_n;
                r_scount  <= SCW'(1);
                r_nsol    <= '0;
            end
            if (i_cmd.pop) begin
                r_scount <= r_scount - 1'b1;
            end
            if (i_cmd.push) begin
                r_scount <= r_scount + 1'b1;
            end
            if (i_cmd.latch) begin
                r_k <= '0;
            end
            if (i_cmd.next) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.child && o_sts.stack_full) begin
                r_run_ovf <= 1'b1;
            end
            if (i_cmd.cmp && hit && list_full) begin
                r_run_ovf <= 1'b1;
            end
            if (i_cmd.leaf && o_sts.sol_full) begin
                r_run_ovf <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_nsol <= r_nsol + 1'b1;
            end
            if (i_cmd.finish) begin
                r_pcount   <= '0;
                r_load_ovf <= 1'b0;
            end
            if (i_cmd.emit || i_cmd.finish) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
endmodule

@@ design/adaptive_hough_helix_search_top.sv @@
// top level of the adaptive hough helix search block
// depends on ahhs_pkg, ahhs_ctrl, ahhs_dp (which holds ahhs_div)

// Load transactions (command 0) store one hit point each and are taken one
// per cycle while the sequencer is idle. A start transaction (command 1)
// holds the input stalled for the whole search: each popped cell is
// latched and evaluated; each child is set up and, unless the stack is
// full, scanned point by point and pushed, as one scan unit reads the
// point list and point stores and runs the two bend multiplies per point.
// Unless the solution limit is reached, a leaf runs the radix-2 radius
// divider before its solution is offered. The run ends with one end-marker
// transaction (is_last set, overflow reporting any dropped point, cell,
// list entry or solution). Solutions wait in a single output register, so a
// stalled output pauses the search. No clearing pass is needed after reset.
module adaptive_hough_helix_search_top #(
    parameter int MAX_POINTS    = ahhs_pkg::MAX_POINTS_DEF,
    parameter int LIST_DEPTH    = ahhs_pkg::LIST_DEPTH_DEF,
    parameter int STACK_DEPTH   = ahhs_pkg::STACK_DEPTH_DEF,
    parameter int MAX_SOLUTIONS = ahhs_pkg::MAX_SOLUTIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ahhs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ahhs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ahhs_pkg::t_in                   i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ahhs_pkg::t_out                  o_out_data
);
    ahhs_pkg::t_cmd cmd;
    ahhs_pkg::t_sts sts;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts a transaction only while idle
    ahhs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .o_in_stall   (o_in_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // storage, scan unit, divider and output register
    ahhs_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .LIST_DEPTH    (LIST_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH),
        .MAX_SOLUTIONS (MAX_SOLUTIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule

@@ design/ahhs_checker.sv @@
// port-level checks for the adaptive hough helix search top level
// depends on ahhs_pkg; bound to adaptive_hough_helix_search_top below
module ahhs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input ahhs_pkg::t_in                   i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input ahhs_pkg::t_out                  o_out_data
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // end marker carries no track
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_last |->
            !o_out_data.solution_valid && o_out_data.hit_count == 8'd0
            && o_out_data.track_radius == 32'sd0 && o_out_data.track_angle == 16'sd0)
        else $error("end marker with track data");

    // solutions never flag overflow or end
    a_sol_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.solution_valid |->
            !o_out_data.is_last && !o_out_data.overflow)
        else $error("solution with end or overflow flag");

    // an accepted start is followed by a stalled input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == ahhs_pkg::CMD_START
            |=> o_in_stall)
        else $error("input taken right after start");
endmodule

bind adaptive_hough_helix_search_top ahhs_checker u_ahhs_checker (.*);
